// ===== src/atpr_pkg.sv =====
// package: types, constants and step functions for the accelerometer tilt pipeline
package atpr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;
    localparam int SQRT_STEPS = 32;
    localparam logic signed [15:0] RIGHT_ANGLE = 16'sd23040;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PORT_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STBD_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_PITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_ROLL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STBD_PITCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STBD_ROLL = 3'd5;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    typedef struct packed {
        logic [6:0] sensor_addr;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic status;
    } t_out_word;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [31:0] sq;
        logic neg;
        logic num_zero;
        logic mag_zero;
        logic [15:0] nabs;
        logic signed [35:0] cx;
        logic signed [35:0] cy;
        logic signed [31:0] acc;
    } t_lane;

    typedef struct packed {
        t_lane p;
        t_lane r;
        logic status;
        logic signed [12:0] off_p;
        logic signed [12:0] off_r;
    } t_stage;

    function automatic logic signed [23:0] atan_q16(input int i);
        logic signed [23:0] v;
        unique case (i)
            0: v = 24'sd2949120;
            1: v = 24'sd1740967;
            2: v = 24'sd919879;
            3: v = 24'sd466945;
            4: v = 24'sd234379;
            5: v = 24'sd117304;
            6: v = 24'sd58666;
            7: v = 24'sd29335;
            8: v = 24'sd14668;
            9: v = 24'sd7334;
            10: v = 24'sd3667;
            11: v = 24'sd1833;
            12: v = 24'sd917;
            13: v = 24'sd458;
            14: v = 24'sd229;
            15: v = 24'sd115;
            16: v = 24'sd57;
            17: v = 24'sd29;
            18: v = 24'sd14;
            19: v = 24'sd7;
            20: v = 24'sd4;
            21: v = 24'sd2;
            22: v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    function automatic t_lane lane_init(input logic signed [15:0] num,
                                        input logic signed [15:0] a,
                                        input logic signed [15:0] b);
        t_lane l;
        logic signed [31:0] aa;
        logic signed [31:0] bb;
        logic signed [16:0] n17;
        aa = a * a;
        bb = b * b;
        n17 = num[15] ? -{num[15], num} : {num[15], num};
        l = '0;
        l.sq = $unsigned(aa) + $unsigned(bb);
        l.neg = num[15];
        l.num_zero = (num == 16'sd0);
        l.mag_zero = (l.sq == 32'd0);
        l.nabs = n17[15:0];
        return l;
    endfunction

    // one result bit of the square root of sq * 2^32
    function automatic t_lane sqrt_step(input t_lane l);
        t_lane o;
        logic [35:0] cur;
        logic [35:0] trial;
        o = l;
        cur = {l.rem, l.sq[31:30]};
        trial = cur - {2'b00, l.root, 2'b01};
        if (!trial[35]) begin
            o.rem = trial[33:0];
            o.root = {l.root[30:0], 1'b1};
        end else begin
            o.rem = cur[33:0];
            o.root = {l.root[30:0], 1'b0};
        end
        o.sq = {l.sq[29:0], 2'b00};
        return o;
    endfunction

    function automatic t_lane cordic_load(input t_lane l);
        t_lane o;
        o = l;
        o.cx = $signed({4'b0000, l.root});
        o.cy = $signed({4'b0000, l.nabs, 16'h0000});
        o.acc = '0;
        return o;
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input int i);
        t_lane o;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [31:0] t;
        o = l;
        dx = l.cy >>> i;
        dy = l.cx >>> i;
        t = 32'(atan_q16(i));
        if (!l.cy[35]) begin
            o.cx = l.cx + dx;
            o.cy = l.cy - dy;
            o.acc = l.acc + t;
        end else begin
            o.cx = l.cx - dx;
            o.cy = l.cy + dy;
            o.acc = l.acc - t;
        end
        return o;
    endfunction

    function automatic logic signed [15:0] lane_finish(input t_lane l,
                                                       input logic signed [12:0] off);
        logic signed [31:0] r;
        logic signed [15:0] ang;
        logic signed [17:0] d;
        logic signed [15:0] s;
        r = (l.acc + 32'sd128) >>> 8;
        if (r < 0) begin
            ang = 16'sd0;
        end else if (r > 32'(RIGHT_ANGLE)) begin
            ang = RIGHT_ANGLE;
        end else begin
            ang = r[15:0];
        end
        if (l.num_zero) begin
            ang = 16'sd0;
        end else if (l.mag_zero) begin
            ang = RIGHT_ANGLE;
        end
        if (l.neg) begin
            ang = -ang;
        end
        d = 18'(ang) - 18'(off);
        if (d > 18'sd32767) begin
            s = 16'sd32767;
        end else if (d < -18'sd32768) begin
            s = -16'sd32768;
        end else begin
            s = d[15:0];
        end
        return s;
    endfunction

endpackage

// ===== src/accel_tilt_pitch_roll_top.sv =====
// top level: pipelined pitch and roll from a three-axis accelerometer word
//
// input channel: i_in_valid / o_in_ready carry one t_in_word (sensor address and
// raw x, y, z counts). output channel: o_out_valid / i_out_ready carry one
// t_out_word (pitch, roll in 1/256 degree, status). config channel:
// i_cfg_valid / o_cfg_ready with register index and data; always ready.
// one word enters per cycle while the receiver does not stall; each word passes
// through 32 square root stages, one stage per arctangent iteration, a squaring
// stage, a load stage and the final rounding stage.
// both angles run in parallel lanes of the same pipeline.
// an unknown address gives status 1 and zero angles.
// reset clears all valid bits and loads the default addresses and offsets.
// when the receiver stalls the whole pipeline holds; nothing is lost or repeated.
module accel_tilt_pitch_roll_top #(
    parameter int CORDIC_STEPS = atpr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  atpr_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output atpr_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [atpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [atpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import atpr_pkg::*;

    localparam int LOAD_ST = SQRT_STEPS + 1;
    localparam int LAST = LOAD_ST + CORDIC_STEPS + 1;

    logic [6:0] r_port_addr;
    logic [6:0] r_stbd_addr;
    logic signed [12:0] r_port_pitch;
    logic signed [12:0] r_port_roll;
    logic signed [12:0] r_stbd_pitch;
    logic signed [12:0] r_stbd_roll;

    t_stage r_stg [0:LAST-1];
    t_stage n_stg [0:LAST-1];
    logic [LAST-1:0] r_vld;
    t_out_word r_out;
    t_out_word n_out;
    logic r_out_vld;
    logic w_en;

    assign w_en = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_addr <= 7'd0;
            r_stbd_addr <= 7'd1;
            r_port_pitch <= '0;
            r_port_roll <= '0;
            r_stbd_pitch <= '0;
            r_stbd_roll <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PORT_ADDR: r_port_addr <= i_cfg_data[6:0];
                REG_STBD_ADDR: r_stbd_addr <= i_cfg_data[6:0];
                REG_PORT_PITCH: r_port_pitch <= $signed(i_cfg_data);
                REG_PORT_ROLL: r_port_roll <= $signed(i_cfg_data);
                REG_STBD_PITCH: r_stbd_pitch <= $signed(i_cfg_data);
                REG_STBD_ROLL: r_stbd_roll <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // entry: squares and offset select
    always_comb begin
        n_stg[0].p = lane_init(i_in_word.raw_y, i_in_word.raw_x, i_in_word.raw_z);
        n_stg[0].r = lane_init(i_in_word.raw_x, i_in_word.raw_y, i_in_word.raw_z);
        n_stg[0].status = STATUS_GOOD;
        n_stg[0].off_p = '0;
        n_stg[0].off_r = '0;
        if (i_in_word.sensor_addr == r_port_addr) begin
            n_stg[0].off_p = r_port_pitch;
            n_stg[0].off_r = r_port_roll;
        end else if (i_in_word.sensor_addr == r_stbd_addr) begin
            n_stg[0].off_p = r_stbd_pitch;
            n_stg[0].off_r = r_stbd_roll;
        end else begin
            n_stg[0].status = STATUS_UNKNOWN;
        end
    end

    for (genvar s = 1; s < LAST; s++) begin : g_st
        always_comb begin
            n_stg[s] = r_stg[s-1];
            if (s <= SQRT_STEPS) begin
                n_stg[s].p = sqrt_step(r_stg[s-1].p);
                n_stg[s].r = sqrt_step(r_stg[s-1].r);
            end else if (s == LOAD_ST) begin
                n_stg[s].p = cordic_load(r_stg[s-1].p);
                n_stg[s].r = cordic_load(r_stg[s-1].r);
            end else begin
                n_stg[s].p = cordic_step(r_stg[s-1].p, s - LOAD_ST - 1);
                n_stg[s].r = cordic_step(r_stg[s-1].r, s - LOAD_ST - 1);
            end
        end
    end

    always_comb begin
        n_out.status = r_stg[LAST-1].status;
        if (r_stg[LAST-1].status == STATUS_UNKNOWN) begin
            n_out.pitch = '0;
            n_out.roll = '0;
        end else begin
            n_out.pitch = lane_finish(r_stg[LAST-1].p, r_stg[LAST-1].off_p);
            n_out.roll = lane_finish(r_stg[LAST-1].r, r_stg[LAST-1].off_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-2:0], i_in_valid};
            r_out_vld <= r_vld[LAST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < LAST; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_out <= n_out;
        end
    end

endmodule

// ===== src/atpr_checker.sv =====
// checker: port-level assertions for the tilt pipeline, bound to the top level
module atpr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input atpr_pkg::t_out_word o_out_word,
    input logic                o_cfg_ready
);
    import atpr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == STATUS_UNKNOWN |->
        o_out_word.pitch == 16'sd0 && o_out_word.roll == 16'sd0)
        else $error("unknown sensor with nonzero angle");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind accel_tilt_pitch_roll_top atpr_checker u_atpr_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_word(o_out_word),
    .o_cfg_ready(o_cfg_ready)
);

// ===== test/accel_tilt_pitch_roll_top_tb.sv =====
// testbench: accelerometer tilt pipeline against a bit-accurate pitch and roll predictor
module accel_tilt_pitch_roll_top_tb;
    import atpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 34;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out_word;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    accel_tilt_pitch_roll_top #(.CORDIC_STEPS(STEPS)) uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [6:0] port_addr_q;
    logic [6:0] stbd_addr_q;
    logic signed [12:0] port_pitch_q, port_roll_q, stbd_pitch_q, stbd_roll_q;

    t_in_word pending_words[$];
    t_out_word expected_angles[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic longint atan_entry(input int i);
        longint tab[24];
        tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint tilt_angle(input longint num, input longint a,
                                          input longint b);
        longint unsigned sq, n, rem_v, bit_v;
        longint mag, cx, cy, acc, dx, dy, ang, nabs;
        sq = longint'(a * a + b * b);
        n = sq << 32;
        rem_v = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= rem_v + bit_v) begin
                n -= rem_v + bit_v;
                rem_v = (rem_v >> 1) + bit_v;
            end else begin
                rem_v >>= 1;
            end
            bit_v >>= 2;
        end
        mag = longint'(rem_v);
        if (num == 0) return 0;
        if (mag == 0) return num < 0 ? -23040 : 23040;
        nabs = num < 0 ? -num : num;
        cx = mag;
        cy = nabs * 65536;
        acc = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                acc += atan_entry(i);
            end else begin
                cx -= dx;
                cy += dy;
                acc -= atan_entry(i);
            end
        end
        ang = (acc + 128) >>> 8;
        if (ang < 0) ang = 0;
        if (ang > 23040) ang = 23040;
        return num < 0 ? -ang : ang;
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_out_word predict_angles(input t_in_word w);
        t_out_word o;
        longint op, orl;
        o = '0;
        if (w.sensor_addr == port_addr_q) begin
            op = port_pitch_q;
            orl = port_roll_q;
        end else if (w.sensor_addr == stbd_addr_q) begin
            op = stbd_pitch_q;
            orl = stbd_roll_q;
        end else begin
            o.status = STATUS_UNKNOWN;
            return o;
        end
        o.pitch = sat16(tilt_angle(w.raw_y, w.raw_x, w.raw_z) - op);
        o.roll = sat16(tilt_angle(w.raw_x, w.raw_y, w.raw_z) - orl);
        o.status = STATUS_GOOD;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_angles.push_back(predict_angles(i_in_word));
                send_gap <= rand_gap();
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (i_in_valid && o_in_ready && send_gap != 0) begin
                    i_in_valid <= 1'b0;
                end else if (i_in_valid && o_in_ready) begin
                    if (pending_words.size() > 0) begin
                        i_in_word <= pending_words.pop_front();
                    end else begin
                        i_in_valid <= 1'b0;
                    end
                end else if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() > 0) begin
                    i_in_word <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        int g;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("unexpected word", o_out_word.pitch, 0);
                end else begin
                    want = expected_angles.pop_front();
                    if (o_out_word.pitch !== want.pitch)
                        report_mismatch("pitch", o_out_word.pitch, want.pitch);
                    if (o_out_word.roll !== want.roll)
                        report_mismatch("roll", o_out_word.roll, want.roll);
                    if (o_out_word.status !== want.status)
                        report_mismatch("status", o_out_word.status, want.status);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                g = rand_gap();
                recv_gap <= g;
                i_out_ready <= (g == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // leaves the write valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        unique case (idx)
            REG_PORT_ADDR: port_addr_q = val[6:0];
            REG_STBD_ADDR: stbd_addr_q = val[6:0];
            REG_PORT_PITCH: port_pitch_q = val;
            REG_PORT_ROLL: port_roll_q = val;
            REG_STBD_PITCH: stbd_pitch_q = val;
            REG_STBD_ROLL: stbd_roll_q = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || expected_angles.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r == 2) return 16'h0000;
        if (r == 3) return 16'($urandom_range(0, 6)) - 16'd3;
        return 16'($urandom);
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) w.sensor_addr = port_addr_q;
        else if (r < 8) w.sensor_addr = stbd_addr_q;
        else w.sensor_addr = 7'($urandom);
        w.raw_x = rand_axis();
        w.raw_y = rand_axis();
        w.raw_z = rand_axis();
        return w;
    endfunction

    task automatic add_word(input logic [6:0] a, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z);
        t_in_word w;
        w.sensor_addr = a;
        w.raw_x = x;
        w.raw_y = y;
        w.raw_z = z;
        pending_words.push_back(w);
    endtask

    initial begin
        port_addr_q = 7'd0;
        stbd_addr_q = 7'd1;
        port_pitch_q = '0;
        port_roll_q = '0;
        stbd_pitch_q = '0;
        stbd_roll_q = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, zero axes, vertical, extremes, unknown address
        add_word(7'd0, 16'h0000, 16'h0000, 16'h0000);
        add_word(7'd0, 16'h0000, 16'h0005, 16'h0000);
        add_word(7'd1, 16'h8000, 16'h0000, 16'h0000);
        add_word(7'd1, 16'h0000, 16'hfffb, 16'h0000);
        add_word(7'd0, 16'h7fff, 16'h7fff, 16'h7fff);
        add_word(7'd0, 16'h8000, 16'h8000, 16'h8000);
        add_word(7'd1, 16'h0000, 16'h0000, 16'h4000);
        add_word(7'd0, 16'h0001, 16'hffff, 16'h8000);
        add_word(7'd127, 16'h1234, 16'h5678, 16'h0100);
        add_word(7'd2, 16'h8000, 16'h7fff, 16'h0000);
        wait_drained();

        write_reg(REG_PORT_ADDR, 13'd127);
        write_reg(REG_STBD_ADDR, 13'd127);
        write_reg(REG_PORT_PITCH, 13'h1000);
        write_reg(REG_PORT_ROLL, 13'h0fff);
        write_reg(REG_STBD_PITCH, 13'h0fff);
        write_reg(REG_STBD_ROLL, 13'h1000);
        write_reg(3'd6, 13'h1fff);
        write_reg(3'd7, 13'h0555);
        i_cfg_valid <= 1'b0;
        add_word(7'd127, 16'h0000, 16'h8000, 16'h0000);
        add_word(7'd127, 16'h8000, 16'h0000, 16'h0000);
        add_word(7'd127, 16'h7fff, 16'h7fff, 16'h0000);
        add_word(7'd0, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_PORT_ADDR, 13'($urandom));
            write_reg(REG_STBD_ADDR, 13'($urandom));
            write_reg(REG_PORT_PITCH, 13'($urandom));
            write_reg(REG_PORT_ROLL, 13'($urandom));
            write_reg(REG_STBD_PITCH, (ph == 0) ? 13'h1000 : 13'($urandom));
            write_reg(REG_STBD_ROLL, (ph == 0) ? 13'h0fff : 13'($urandom));
            i_cfg_valid <= 1'b0;
            for (int k = 0; k < 300; k++) pending_words.push_back(rand_word());
            wait_drained();
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
